[design/bleusc_pkg.sv]
// bleusc_pkg: types, widths, stage numbering and constant tables for the bleu score pipeline
// used by bleusc_stage and bleu_score_from_stats_top; no dependencies
`default_nettype none

package bleusc_pkg;

   localparam int NGRAM_ORDER  = 4;
   localparam int COUNT_WIDTH  = 24;
   localparam int NV           = 2 * NGRAM_ORDER;
   localparam int ORDER_SHIFT  = $clog2(NGRAM_ORDER);
   localparam int SMOOTH_W     = 12;
   localparam int SMOOTH_FRAC  = 8;
   localparam int FRAC         = 16;
   localparam int HW           = COUNT_WIDTH + SMOOTH_FRAC;
   localparam int VW           = HW + 1;
   localparam int MW           = 31;
   localparam int LIW          = $clog2(VW);
   localparam int LW           = LIW + FRAC;
   localparam int QW           = 23;
   localparam int RW           = VW + FRAC;
   localparam int DW           = HW + QW;
   localparam int SW           = LW + ORDER_SHIFT + 1;
   localparam int PW           = 23;
   localparam int L2W          = 17;
   localparam int PLW          = PW + L2W - FRAC;
   localparam int TW           = 26;
   localparam int KW           = 6;
   localparam int SHW          = 7;
   localparam int SCW          = 17;
   localparam int CSR_IW       = 2;

   localparam logic [SCW-1:0]      ONE_Q16     = SCW'(65536);
   localparam logic [L2W-1:0]      LOG2E_Q16   = L2W'(94548);
   localparam logic [PW-1:0]       PEN_MAX     = PW'(64 * 65536);
   localparam logic [TW-1:0]       EXP_LIMIT   = TW'(40 * 65536);
   localparam logic [SHW-1:0]      EXP_SHIFT   = SHW'(14);
   localparam logic [MW-1:0]       MANT_ONE    = MW'(1) << (MW - 1);
   localparam logic [SMOOTH_W-1:0] SMOOTH_RST  = SMOOTH_W'(256);

   // stage numbering
   localparam int S_PREP    = 0;
   localparam int S_LEAD    = 1;
   localparam int S_NORM    = 2;
   localparam int SQ_FIRST  = 3;
   localparam int DIV_FIRST = S_NORM;
   localparam int DIV_LAST  = DIV_FIRST + QW - 1;
   localparam int S_SUM     = SQ_FIRST + FRAC;
   localparam int S_PEN     = DIV_LAST + 1;
   localparam int S_PMUL    = S_PEN + 1;
   localparam int S_TOT     = S_PMUL + 1;
   localparam int S_EPREP   = S_TOT + 1;
   localparam int EXP_FIRST = S_EPREP + 1;
   localparam int S_FIN     = EXP_FIRST + FRAC;
   localparam int NSTAGE    = S_FIN + 1;

   typedef enum logic [CSR_IW-1:0] {
      REG_SMOOTHED_MODE    = 2'd0,
      REG_SMOOTHING_AMOUNT = 2'd1,
      REG_SMOOTH_BREVITY   = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] matched_unigrams;
      logic [COUNT_WIDTH-1:0] hyp_unigrams;
      logic [COUNT_WIDTH-1:0] matched_bigrams;
      logic [COUNT_WIDTH-1:0] hyp_bigrams;
      logic [COUNT_WIDTH-1:0] matched_trigrams;
      logic [COUNT_WIDTH-1:0] hyp_trigrams;
      logic [COUNT_WIDTH-1:0] matched_fourgrams;
      logic [COUNT_WIDTH-1:0] hyp_fourgrams;
      logic [COUNT_WIDTH-1:0] ref_length;
   } req_word_type;

   typedef struct packed {
      logic [SCW-1:0] score;
      logic           degenerate;
   } rsp_word_type;

   typedef struct packed {
      logic [NV-1:0][VW-1:0] vals;
      logic [NV-1:0][LW-1:0] lg;
      logic [VW-1:0]         rr;
      logic [HW-1:0]         h1;
      logic [RW-1:0]         rem;
      logic [QW-1:0]         q;
      logic                  qsat;
      logic                  brev;
      logic                  degen;
      logic                  zero;
      logic signed [SW-1:0]  sum;
      logic [PW-1:0]         pen;
      logic [PLW-1:0]        penlog;
      logic signed [TW-1:0]  total;
      logic                  big;
      logic                  tiny;
      logic [KW-1:0]         k;
      logic [FRAC-1:0]       f;
      logic [MW-1:0]         em;
      logic [SCW-1:0]        score;
   } pipe_type;

   function automatic longint unsigned isqrt(input longint unsigned x_in);
      longint unsigned x;
      longint unsigned r;
      longint unsigned b;
      x = x_in;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-idx) in Q30 by repeated floor square roots of 2.0
   function automatic logic [MW-1:0] exp_factor(input int idx);
      longint unsigned t;
      t = 64'h1 << MW;
      for (int n = 1; n <= idx; n++) t = isqrt(t << (MW - 1));
      return t[MW-1:0];
   endfunction

endpackage

`default_nettype wire

[design/bleusc_stage.sv]
// bleusc_stage: one register stage of the bleu score pipeline, its operation chosen by STAGE
// depends on bleusc_pkg
`default_nettype none

module bleusc_stage #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bleusc_pkg::pipe_type in_data,
   output logic                in_ready,
   input  logic                out_ready,
   output logic                out_valid,
   output bleusc_pkg::pipe_type out_data
);
   import bleusc_pkg::*;

   localparam bit IS_DIV = (STAGE >= DIV_FIRST) && (STAGE <= DIV_LAST);
   localparam int DBIT   = IS_DIV ? DIV_LAST - STAGE : 0;
   localparam bit IS_SQ  = (STAGE >= SQ_FIRST) && (STAGE < SQ_FIRST + FRAC);
   localparam int LBIT   = IS_SQ ? FRAC - 1 - (STAGE - SQ_FIRST) : 0;
   localparam bit IS_EXP = (STAGE >= EXP_FIRST) && (STAGE < EXP_FIRST + FRAC);
   localparam int EBIT   = IS_EXP ? FRAC - 1 - (STAGE - EXP_FIRST) : 0;
   localparam logic [MW-1:0] FACTOR = exp_factor(IS_EXP ? STAGE - EXP_FIRST + 1 : 1);

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;

   function automatic logic [LIW-1:0] lead_pos(input logic [VW-1:0] v);
      logic [LIW-1:0] p;
      p = '0;
      for (int i = 0; i < VW; i++) if (v[i]) p = LIW'(i);
      return p;
   endfunction

   always_comb begin
      logic [VW+MW-2:0]     wide;
      logic [2*MW-1:0]      sq;
      logic [DW-1:0]        dsh;
      logic [PW+L2W-1:0]    prod;
      logic [2*MW-1:0]      eprod;
      logic [TW-1:0]        a;
      logic [SHW-1:0]       sh;
      logic signed [SW-1:0] acc;
      logic signed [TW-1:0] mean_x;
      logic [QW-1:0]        qd;
      data_in = in_data;
      wide = '0;
      sq = '0;
      dsh = '0;
      prod = '0;
      eprod = '0;
      a = '0;
      sh = '0;
      acc = '0;
      mean_x = '0;
      qd = '0;
      if (STAGE == S_LEAD) begin
         for (int v = 0; v < NV; v++) begin
            data_in.lg[v] = LW'(lead_pos(in_data.vals[v])) << FRAC;
         end
         data_in.brev = in_data.rr > VW'(in_data.h1);
         data_in.qsat = (HW+QW-FRAC)'(in_data.rr) >= {in_data.h1, {(QW-FRAC){1'b0}}};
         data_in.rem  = {in_data.rr, {FRAC{1'b0}}};
         data_in.q    = '0;
      end
      if (STAGE == S_NORM) begin
         for (int v = 0; v < NV; v++) begin
            wide = {in_data.vals[v], {(MW-1){1'b0}}} >> in_data.lg[v][LW-1:FRAC];
            data_in.vals[v] = VW'(wide[MW-1:0]);
         end
      end
      if (IS_SQ) begin
         for (int v = 0; v < NV; v++) begin
            sq = in_data.vals[v][MW-1:0] * in_data.vals[v][MW-1:0];
            if (sq[2*MW-1]) begin
               data_in.vals[v] = VW'(sq[2*MW-1:MW]);
               data_in.lg[v][LBIT] = 1'b1;
            end else begin
               data_in.vals[v] = VW'(sq[2*MW-2:MW-1]);
            end
         end
      end
      if (IS_DIV) begin
         dsh = DW'(in_data.h1) << DBIT;
         if (DW'(in_data.rem) >= dsh) begin
            data_in.rem = in_data.rem - dsh[RW-1:0];
            data_in.q[DBIT] = 1'b1;
         end
      end
      if (STAGE == S_SUM) begin
         for (int k = 0; k < NGRAM_ORDER; k++) begin
            acc = acc + SW'(in_data.lg[2*k]) - SW'(in_data.lg[2*k+1]);
         end
         data_in.sum = acc;
      end
      if (STAGE == S_PEN) begin
         qd = in_data.q - QW'(ONE_Q16);
         if (!in_data.brev) data_in.pen = '0;
         else if (in_data.qsat || (qd > PEN_MAX)) data_in.pen = PEN_MAX;
         else data_in.pen = qd;
      end
      if (STAGE == S_PMUL) begin
         prod = in_data.pen * LOG2E_Q16;
         data_in.penlog = prod[PW+L2W-1:FRAC];
      end
      if (STAGE == S_TOT) begin
         mean_x = TW'(in_data.sum >>> ORDER_SHIFT);
         data_in.total = mean_x - $signed(TW'(in_data.penlog));
      end
      if (STAGE == S_EPREP) begin
         a = -in_data.total;
         data_in.big  = !in_data.total[TW-1];
         data_in.tiny = a > EXP_LIMIT;
         data_in.k    = KW'(a[TW-1:FRAC] + (TW-FRAC)'(|a[FRAC-1:0]));
         data_in.f    = in_data.total[FRAC-1:0];
         data_in.em   = MANT_ONE;
      end
      if (IS_EXP) begin
         eprod = in_data.em * FACTOR;
         if (in_data.f[EBIT]) data_in.em = eprod[2*MW-2:MW-1];
      end
      if (STAGE == S_FIN) begin
         sh = SHW'(in_data.k) + EXP_SHIFT;
         if (in_data.degen || in_data.zero) data_in.score = '0;
         else if (in_data.big) data_in.score = ONE_Q16;
         else if (in_data.tiny || (sh >= SHW'(MW))) data_in.score = '0;
         else data_in.score = SCW'(in_data.em >> sh);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[design/bleu_score_from_stats_top.sv]
// bleu_score_from_stats_top: pipelined bleu score from n-gram statistics, csr registers
// depends on bleusc_pkg and bleusc_stage
//
// usage:
//   req channel (req_valid, req_stall, req_word) takes one word of nine statistics;
//   rsp channel (rsp_valid, rsp_stall, rsp_word) returns score (Q1.16) and degenerate.
//   a word moves at a clock edge with valid high and stall low.
//   csr channel (csr_valid, csr_ready, csr_index, csr_data) writes smoothed_mode (0),
//   smoothing_amount (1) and smooth_brevity (2); csr_ready is always high and other
//   indexes are ignored. write only while the pipeline is empty.
//   pipeline: 46 register stages: setup, leading one, normalize, 16 log squaring
//   stages, log sum, 5 more divider stages, with the 23 quotient-bit divider stages
//   running alongside from normalize on, then penalty, penalty multiply, total, exp
//   setup, 16 exp multiplier stages, final shift.
//   throughput: one word per cycle while rsp_stall is low, set by the single-word-per-stage pipeline.
//   a stalled rsp holds its word; stages behind it keep filling empty slots and
//   req_stall rises only once every stage holds a word.
//   reset clears all stage valid bits and loads the csr defaults (0, 256, 0).
`default_nettype none

module bleu_score_from_stats_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bleusc_pkg::req_word_type             req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bleusc_pkg::rsp_word_type             rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bleusc_pkg::CSR_IW-1:0]        csr_index,
   input  logic [bleusc_pkg::SMOOTH_W-1:0]      csr_data
);
   import bleusc_pkg::*;

   logic                smoothed_mode_ff, smoothed_mode_in;
   logic [SMOOTH_W-1:0] smoothing_amount_ff, smoothing_amount_in;
   logic                smooth_brevity_ff, smooth_brevity_in;

   pipe_type                  prep;
   pipe_type                  stage_data [NSTAGE];
   logic     [NSTAGE-1:0]     stage_valid;
   logic     [NSTAGE-1:0]     stage_ready;
   logic [NV-1:0][COUNT_WIDTH-1:0] cnt;
   logic [SMOOTH_W-1:0]       s;

   assign csr_ready = 1'b1;

   always_comb begin
      smoothed_mode_in    = smoothed_mode_ff;
      smoothing_amount_in = smoothing_amount_ff;
      smooth_brevity_in   = smooth_brevity_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SMOOTHED_MODE:    smoothed_mode_in    = csr_data[0];
            REG_SMOOTHING_AMOUNT: smoothing_amount_in = csr_data;
            REG_SMOOTH_BREVITY:   smooth_brevity_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_mode_ff    <= 1'b0;
         smoothing_amount_ff <= SMOOTH_RST;
         smooth_brevity_ff   <= 1'b0;
      end else begin
         smoothed_mode_ff    <= smoothed_mode_in;
         smoothing_amount_ff <= smoothing_amount_in;
         smooth_brevity_ff   <= smooth_brevity_in;
      end
   end

   assign cnt[0] = req_word.matched_unigrams;
   assign cnt[1] = req_word.hyp_unigrams;
   assign cnt[2] = req_word.matched_bigrams;
   assign cnt[3] = req_word.hyp_bigrams;
   assign cnt[4] = req_word.matched_trigrams;
   assign cnt[5] = req_word.hyp_trigrams;
   assign cnt[6] = req_word.matched_fourgrams;
   assign cnt[7] = req_word.hyp_fourgrams;
   assign s = smoothed_mode_ff ? smoothing_amount_ff : '0;

   // counts widened to Q.8 plus smoothing; also the unigram and reference lengths and the degenerate and zero flags
   always_comb begin
      prep = '0;
      for (int v = 0; v < NV; v++) begin
         prep.vals[v] = VW'({cnt[v], {SMOOTH_FRAC{1'b0}}}) + VW'(s);
      end
      prep.h1 = {req_word.hyp_unigrams, {SMOOTH_FRAC{1'b0}}};
      prep.rr = VW'({req_word.ref_length, {SMOOTH_FRAC{1'b0}}})
              + ((smoothed_mode_ff && smooth_brevity_ff) ? VW'(s) : VW'(0));
      prep.degen = (prep.h1 == '0);
      for (int k = 0; k < NGRAM_ORDER; k++) begin
         if (prep.vals[2*k+1] == '0) prep.degen = 1'b1;
         if (prep.vals[2*k] == '0) prep.zero = 1'b1;
      end
   end

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      logic     up_valid;
      pipe_type up_data;
      logic     down_ready;
      if (g == 0) begin : g_first
         assign up_valid = req_valid;
         assign up_data  = prep;
      end else begin : g_mid
         assign up_valid = stage_valid[g-1];
         assign up_data  = stage_data[g-1];
      end
      if (g == NSTAGE - 1) begin : g_last
         assign down_ready = !rsp_stall;
      end else begin : g_inner
         assign down_ready = stage_ready[g+1];
      end
      bleusc_stage #(
         .STAGE(g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (up_valid),
         .in_data   (up_data),
         .in_ready  (stage_ready[g]),
         .out_ready (down_ready),
         .out_valid (stage_valid[g]),
         .out_data  (stage_data[g])
      );
   end

   assign req_stall           = !stage_ready[0];
   assign rsp_valid           = stage_valid[NSTAGE-1];
   assign rsp_word.score      = stage_data[NSTAGE-1].score;
   assign rsp_word.degenerate = stage_data[NSTAGE-1].degen;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.degenerate |-> rsp_word.score == '0)
      else $error("degenerate word with nonzero score");
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.score <= ONE_Q16)
      else $error("score above one");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp side free");
`endif

endmodule

`default_nettype wire

[test/bleu_score_from_stats_top_tb.sv]
// bleu_score_from_stats_top_tb: self-checking testbench for the bleu score pipeline
// predicts each score word in integer arithmetic and compares rsp words in order
// depends on bleusc_pkg and bleu_score_from_stats_top
`default_nettype none

module bleu_score_from_stats_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bleusc_pkg::*;

   localparam int LATENCY = 46;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [SMOOTH_W-1:0] csr_data = '0;

   bleu_score_from_stats_top i_dut (.*);

   always #4 clock = ~clock;

   req_word_type stats_queue[$];
   rsp_word_type score_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit stall_pattern_on = 1'b1;

   logic mode_cfg = 1'b0;
   logic [11:0] smooth_cfg = 12'd256;
   logic brev_cfg = 1'b0;

   function automatic longint unsigned floor_sqrt(input longint unsigned xin);
      longint unsigned x, r, b;
      x = xin;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_fixed(input longint unsigned v);
      int p;
      longint unsigned m;
      longint res;
      p = 0;
      while (p < 63 && (v >> (p + 1)) != 0) p++;
      m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
      res = longint'(p) << 16;
      for (int i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'h1 << 31)) begin
            m = m >> 1;
            res = res | (64'sh1 << (16 - i));
         end
      end
      return res;
   endfunction

   function automatic longint unsigned pow2_neg(input longint unsigned a);
      longint unsigned tab[17];
      longint unsigned k, f, m, sh;
      if (a > (64'd40 << 16)) return 0;
      tab[0] = 64'd2 << 30;
      for (int i = 1; i <= 16; i++) tab[i] = floor_sqrt(tab[i-1] << 30);
      m = 64'h1 << 30;
      k = (a + 65535) >> 16;
      f = (k << 16) - a;
      for (int i = 1; i <= 16; i++)
         if ((f >> (16 - i)) & 1) m = (m * tab[i]) >> 30;
      sh = 14 + k;
      if (sh >= 63) return 0;
      return m >> sh;
   endfunction

   function automatic rsp_word_type bleu_predict(input req_word_type w);
      longint unsigned cnt[9];
      longint unsigned num, den, s, h1, rr, q, pen;
      longint sum, mean, total;
      longint unsigned sc;
      bit zero_num, degen;
      rsp_word_type o;
      cnt = '{w.matched_unigrams, w.hyp_unigrams, w.matched_bigrams, w.hyp_bigrams,
              w.matched_trigrams, w.hyp_trigrams, w.matched_fourgrams, w.hyp_fourgrams,
              w.ref_length};
      s = mode_cfg ? smooth_cfg : 0;
      sum = 0;
      zero_num = 0;
      degen = 0;
      for (int k = 0; k < 4; k++) begin
         num = (cnt[2*k] << 8) + s;
         den = (cnt[2*k+1] << 8) + s;
         if (den == 0) degen = 1;
         if (num == 0) zero_num = 1;
         if (num != 0 && den != 0) sum = sum + log2_fixed(num) - log2_fixed(den);
      end
      h1 = cnt[1] << 8;
      if (h1 == 0) degen = 1;
      o.degenerate = degen;
      o.score = '0;
      if (degen || zero_num) return o;
      if (sum >= 0) mean = sum / 4;
      else mean = -longint'((unsigned'(-sum) + 3) / 4);
      rr = cnt[8] << 8;
      if (mode_cfg && brev_cfg) rr = rr + s;
      total = mean;
      if (rr > h1) begin
         q = (rr << 16) / h1;
         pen = q - 65536;
         if (pen > (64'd64 << 16)) pen = 64'd64 << 16;
         total = total - longint'((pen * 94548) >> 16);
      end
      if (total >= 0) sc = 65536;
      else sc = pow2_neg(unsigned'(-total));
      if (sc > 65536) sc = 65536;
      o.score = sc[16:0];
      return o;
   endfunction

   function automatic logic [23:0] rand_count(input int bias);
      case ($urandom_range(0, 5))
         0: return 24'($urandom_range(0, 3));
         1: return 24'hFFFFFF - 24'($urandom_range(0, 3));
         2: return 24'($urandom);
         default: return 24'($urandom_range(bias / 2 + 1, bias + 2));
      endcase
   endfunction

   function automatic req_word_type rand_stats();
      req_word_type w;
      int len;
      len = $urandom_range(1, 80);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 1 << 22);
      if ($urandom_range(0, 4) == 0) begin
         return req_word_type'(($bits(req_word_type))'({$urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom,
                                                        $urandom}));
      end
      w.hyp_unigrams = 24'(len);
      w.hyp_bigrams = 24'(len > 1 ? len - 1 : $urandom_range(0, 1));
      w.hyp_trigrams = 24'(len > 2 ? len - 2 : $urandom_range(0, 1));
      w.hyp_fourgrams = 24'(len > 3 ? len - 3 : $urandom_range(0, 1));
      w.matched_unigrams = 24'($urandom_range(0, len));
      w.matched_bigrams = 24'($urandom_range(0, w.hyp_bigrams));
      w.matched_trigrams = 24'($urandom_range(0, w.hyp_trigrams));
      w.matched_fourgrams = 24'($urandom_range(0, w.hyp_fourgrams));
      w.ref_length = 24'($urandom_range(len / 2, len * 2 + 1));
      if ($urandom_range(0, 15) == 0) w.ref_length = rand_count(len);
      if ($urandom_range(0, 15) == 0) w.hyp_trigrams = rand_count(len);
      return w;
   endfunction

   task automatic csr_write(input csr_reg_type idx, input logic [11:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SMOOTHED_MODE: mode_cfg = data[0];
         REG_SMOOTHING_AMOUNT: smooth_cfg = data;
         REG_SMOOTH_BREVITY: brev_cfg = data[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (stats_queue.size() != 0 || score_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            score_queue.insert(score_queue.size(), bleu_predict(stats_queue.pop_front()));
         end
         if (req_valid && req_stall) begin
         end else if (stats_queue.size() > 0 && gap_left == 0) begin
            req_valid <= 1'b1;
            req_word <= stats_queue[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                             $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern and monitor
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (score_queue.size() == 0) begin
               $display("%0t unexpected rsp word actual score=%0d degenerate=%0d",
                        $time, rsp_word.score, rsp_word.degenerate);
               errors++;
            end else begin
               exp_word = score_queue.pop_front();
               if (rsp_word.score !== exp_word.score) begin
                  $display("%0t score mismatch expected %0d actual %0d",
                           $time, exp_word.score, rsp_word.score);
                  errors++;
               end
               if (rsp_word.degenerate !== exp_word.degenerate) begin
                  $display("%0t degenerate mismatch expected %0d actual %0d",
                           $time, exp_word.degenerate, rsp_word.degenerate);
                  errors++;
               end
            end
         end
         if (hold_off) rsp_stall <= 1'b1;
         else if (stall_pattern_on) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (stats_queue.size() == 0 && score_queue.size() == 0)) begin
         idle_cycles <= 0;
      end else if (!hold_off) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bleu_score_from_stats_top regression: fail");
            $finish;
         end
      end
   end

   task automatic push_stats(input logic [23:0] m1, h1, m2, h2, m3, h3, m4, h4, r);
      req_word_type w;
      w = '{m1, h1, m2, h2, m3, h3, m4, h4, r};
      stats_queue.insert(stats_queue.size(), w);
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) stats_queue.insert(stats_queue.size(), rand_stats());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed, reset settings (plain mode)
      push_stats(5, 5, 4, 4, 3, 3, 2, 2, 5);
      push_stats(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_stats(3, 5, 2, 4, 1, 3, 1, 0, 5);
      push_stats(3, 5, 0, 4, 1, 3, 1, 2, 5);
      push_stats(10, 10, 9, 9, 8, 8, 7, 7, 40);
      push_stats(1, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 24'hFFFFFF);
      push_stats(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
      push_stats(24'hFFFFFF, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 0);
      push_stats(1, 1, 1, 1, 1, 1, 1, 1, 24'hFFFFFF);
      push_stats(7, 9, 5, 8, 3, 7, 2, 6, 8);
      drain();
      csr_write(REG_SMOOTHED_MODE, 12'd1);
      csr_write(REG_SMOOTH_BREVITY, 12'd1);
      push_stats(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_stats(0, 5, 0, 4, 0, 3, 0, 2, 6);
      push_stats(4, 5, 3, 4, 0, 3, 0, 0, 5);
      push_stats(24'hFFFFFF, 24'hFFFFFF, 0, 24'hFFFFFF, 1, 1, 2, 2, 24'hFFFFFF);
      drain();
      csr_write(REG_SMOOTHING_AMOUNT, 12'd0);
      push_stats(0, 5, 2, 4, 1, 3, 1, 2, 5);
      push_stats(5, 5, 4, 0, 3, 3, 2, 2, 5);
      push_stats(5, 5, 4, 4, 3, 3, 2, 2, 5);
      drain();
      csr_write(REG_SMOOTHING_AMOUNT, 12'hFFF);
      push_stats(0, 1, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
      push_stats(0, 0, 0, 0, 0, 0, 0, 0, 3);
      push_stats(3, 5, 2, 4, 1, 3, 1, 2, 4);
      drain();
      // random phases over several settings
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_SMOOTHED_MODE, 12'($urandom_range(0, 1)));
         csr_write(REG_SMOOTHING_AMOUNT, (ph == 2) ? 12'd0 : (ph == 5) ? 12'hFFF :
                   12'($urandom_range(0, 4095)));
         csr_write(REG_SMOOTH_BREVITY, 12'($urandom));
         if (ph == 3) begin
            stall_pattern_on = 1'b0;
            random_phase(100);
            while (stats_queue.size() != 0) @(posedge clock);
            stall_pattern_on = 1'b1;
         end
         if (ph == 4) begin
            hold_off = 1'b1;
            random_phase(120);
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            random_phase(200);
         end
         drain();
      end
      if (errors == 0) begin
         $display("bleu_score_from_stats_top regression: pass");
      end else begin
         $display("bleu_score_from_stats_top regression: fail");
      end
      $finish;
   end
endmodule

`default_nettype wire
